/* hdl/ctbp_pkg.sv */
package ctbp_pkg;

  localparam int KEY_W = 64;
  localparam int TIME_W = 48;
  localparam int SIZE_W = 16;
  localparam int PER_W = 20;
  localparam int PROD_W = SIZE_W + PER_W;

  localparam logic [1:0] OUT_SERVED = 2'd0;
  localparam logic [1:0] OUT_NEW = 2'd1;
  localparam logic [1:0] OUT_EMPTY = 2'd2;
  localparam logic [1:0] OUT_FULL = 2'd3;

  localparam logic [2:0] ADDR_SIZE = 3'd0;
  localparam logic [2:0] ADDR_PER = 3'd4;

  localparam logic [SIZE_W-1:0] SIZE_RST = 16'd100;
  localparam logic [PER_W-1:0] PER_RST = 20'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_DIV,
    ST_WB,
    ST_NEW,
    ST_SWRD,
    ST_SWDIV,
    ST_SWWB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

/* hdl/client_token_bucket_policer.sv */
// Per-client token bucket policer. One request is handled at a time; in_stall
// is high while one is in work. The table lives in one synchronous memory and
// is searched one entry at a time (read, then compare); a hit then runs a
// 36-step serial divide of the clamped elapsed time by the period with its
// setup, one writeback and one result state. A miss walks all TABLE_ENTRIES
// entries, and a miss into a full table adds one refill sweep over every
// entry that divides and writes back each valid one. A stall on the result
// holds the block in its result state. No clearing pass: valid bits sit in
// flip-flops cleared by reset.
module client_token_bucket_policer #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_client_key,
  input  logic [47:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_limited,
  output logic [1:0]  out_outcome,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int ENT_W = ctbp_pkg::KEY_W + ctbp_pkg::SIZE_W + ctbp_pkg::TIME_W;

  logic [ctbp_pkg::SIZE_W-1:0] size_r;
  logic [ctbp_pkg::PER_W-1:0] per_r;
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [CNT_W-1:0] ecnt_r;
  logic [ENT_W-1:0] mem [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [ENT_W-1:0] wr_data;

  ctbp_pkg::state_t st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [63:0] key_r;
  logic [47:0] now_r;
  logic lim_r, lim_nxt;
  logic [1:0] oc_r, oc_nxt;
  logic [ENT_W-1:0] ent_r;
  ctbp_pkg::div_ctl_t dctl;
  logic ddone;
  logic [ctbp_pkg::SIZE_W-1:0] dq;
  logic [ctbp_pkg::TIME_W-1:0] el_in;
  logic [ctbp_pkg::SIZE_W:0] tot;
  logic [ctbp_pkg::SIZE_W-1:0] newcnt;
  logic [IDX_W-1:0] idx_lo;
  logic [ctbp_pkg::KEY_W-1:0] e_key;
  logic [ctbp_pkg::SIZE_W-1:0] e_cnt;
  logic [ctbp_pkg::TIME_W-1:0] e_time;
  logic vld_clr, vld_set;
  logic cfg_wr;

  assign idx_lo = idx_r[IDX_W-1:0];
  assign {e_key, e_cnt, e_time} = ent_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr)
      ctbp_pkg::ADDR_SIZE: cfg_prdata = {16'd0, size_r};
      ctbp_pkg::ADDR_PER: cfg_prdata = {12'd0, per_r};
      default: cfg_prdata = '0;
    endcase
  end

  // the entry is in rd_q whenever the divider starts
  assign el_in = now_r - rd_q[ctbp_pkg::TIME_W-1:0];

  ctbp_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .elapsed(el_in),
    .size(size_r), .period(per_r), .done(ddone), .quot(dq)
  );

  assign tot = {1'b0, e_cnt} + {1'b0, dq};
  assign newcnt = (tot > {1'b0, size_r}) ? size_r : tot[ctbp_pkg::SIZE_W-1:0];

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    free_nxt = free_r;
    free_ok_nxt = free_ok_r;
    lim_nxt = lim_r;
    oc_nxt = oc_r;
    rd_addr = idx_lo;
    wr_en = 1'b0;
    wr_addr = idx_lo;
    wr_data = ent_r;
    dctl = '0;
    vld_clr = 1'b0;
    vld_set = 1'b0;
    unique case (st_r)
      ctbp_pkg::ST_IDLE: begin
        idx_nxt = '0;
        free_ok_nxt = 1'b0;
        if (in_valid) st_nxt = ctbp_pkg::ST_SCAN;
      end
      ctbp_pkg::ST_SCAN: begin
        // rd_q then holds entry idx from the read issued here; check in ST_RD
        st_nxt = ctbp_pkg::ST_RD;
      end
      ctbp_pkg::ST_RD: begin
        if (vld_r[idx_lo] && rd_q[ENT_W-1 -: ctbp_pkg::KEY_W] == key_r) begin
          dctl.start = 1'b1;
          st_nxt = ctbp_pkg::ST_DIV;
        end else begin
          if (!vld_r[idx_lo] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt = idx_lo;
          end
          if (idx_r == CNT_W'(TABLE_ENTRIES - 1)) begin
            if (ecnt_r >= CNT_W'(TABLE_ENTRIES)) begin
              idx_nxt = '0;
              st_nxt = ctbp_pkg::ST_SWRD;
            end else st_nxt = ctbp_pkg::ST_NEW;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt = ctbp_pkg::ST_SCAN;
          end
        end
      end
      ctbp_pkg::ST_DIV: if (ddone) st_nxt = ctbp_pkg::ST_WB;
      ctbp_pkg::ST_WB: begin
        wr_en = 1'b1;
        if (newcnt == '0) begin
          wr_data = {e_key, newcnt, e_time};
          lim_nxt = 1'b1;
          oc_nxt = ctbp_pkg::OUT_EMPTY;
        end else begin
          wr_data = {e_key, newcnt - 1'b1, now_r};
          lim_nxt = 1'b0;
          oc_nxt = ctbp_pkg::OUT_SERVED;
        end
        st_nxt = ctbp_pkg::ST_OUT;
      end
      ctbp_pkg::ST_NEW: begin
        if (!free_ok_r) begin
          lim_nxt = 1'b1;
          oc_nxt = ctbp_pkg::OUT_FULL;
        end else begin
          wr_en = 1'b1;
          wr_addr = free_r;
          wr_data = {key_r, (size_r == '0) ? size_r : size_r - 1'b1, now_r};
          vld_set = 1'b1;
          lim_nxt = 1'b0;
          oc_nxt = ctbp_pkg::OUT_NEW;
        end
        st_nxt = ctbp_pkg::ST_OUT;
      end
      ctbp_pkg::ST_SWRD: begin
        if (idx_r == CNT_W'(TABLE_ENTRIES)) st_nxt = ctbp_pkg::ST_NEW;
        else if (!vld_r[idx_lo]) idx_nxt = idx_r + 1'b1;
        else st_nxt = ctbp_pkg::ST_SWDIV;
      end
      ctbp_pkg::ST_SWDIV: begin
        // ent_r loads from rd_q while the divider starts
        dctl.start = 1'b1;
        st_nxt = ctbp_pkg::ST_SWWB;
      end
      ctbp_pkg::ST_SWWB: begin
        if (ddone) begin
          wr_en = 1'b1;
          wr_data = {e_key, newcnt, e_time};
          if (newcnt == size_r) begin
            vld_clr = 1'b1;
            if (!free_ok_r) begin
              free_ok_nxt = 1'b1;
              free_nxt = idx_lo;
            end
          end
          idx_nxt = idx_r + 1'b1;
          st_nxt = ctbp_pkg::ST_SWRD;
        end
      end
      ctbp_pkg::ST_OUT: if (!out_stall) st_nxt = ctbp_pkg::ST_IDLE;
      default: st_nxt = ctbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ctbp_pkg::ST_IDLE;
      vld_r <= '0;
      ecnt_r <= '0;
      size_r <= ctbp_pkg::SIZE_RST;
      per_r <= ctbp_pkg::PER_RST;
      idx_r <= '0;
      free_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      free_ok_r <= free_ok_nxt;
      if (vld_set) begin
        vld_r[free_r] <= 1'b1;
        ecnt_r <= ecnt_r + 1'b1;
      end else if (vld_clr) begin
        vld_r[idx_lo] <= 1'b0;
        ecnt_r <= ecnt_r - 1'b1;
      end
      if (cfg_wr && cfg_paddr == ctbp_pkg::ADDR_SIZE) size_r <= cfg_pwdata[15:0];
      if (cfg_wr && cfg_paddr == ctbp_pkg::ADDR_PER) per_r <= cfg_pwdata[19:0];
    end
  end

  always_ff @(posedge clk) begin
    free_r <= free_nxt;
    lim_r <= lim_nxt;
    oc_r <= oc_nxt;
    if (st_r == ctbp_pkg::ST_IDLE && in_valid) begin
      key_r <= in_client_key;
      now_r <= in_now_us;
    end
    if (st_r == ctbp_pkg::ST_RD || st_r == ctbp_pkg::ST_SWDIV) ent_r <= rd_q;
  end

  assign in_stall = (st_r != ctbp_pkg::ST_IDLE);
  assign out_valid = (st_r == ctbp_pkg::ST_OUT);
  assign out_limited = lim_r;
  assign out_outcome = oc_r;

endmodule

/* hdl/ctbp_div.sv */
module ctbp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctbp_pkg::div_ctl_t              ctl,
  input  logic [ctbp_pkg::TIME_W-1:0]     elapsed,
  input  logic [ctbp_pkg::SIZE_W-1:0]     size,
  input  logic [ctbp_pkg::PER_W-1:0]      period,
  output logic                            done,
  output logic [ctbp_pkg::SIZE_W-1:0]     quot
);

  // restoring divide of min(elapsed, size*period) by period, one bit a cycle
  localparam int CNT_W = $clog2(ctbp_pkg::PROD_W + 1);

  logic [ctbp_pkg::PER_W-1:0] per_r;
  logic [ctbp_pkg::TIME_W-1:0] el_r;
  logic [ctbp_pkg::SIZE_W-1:0] size_r;
  logic [ctbp_pkg::PROD_W-1:0] cap_r;
  logic [ctbp_pkg::PROD_W-1:0] num_r, num_nxt;
  logic [ctbp_pkg::PER_W:0] rem_r, rem_nxt;
  logic [ctbp_pkg::SIZE_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0] ph_r;
  logic [ctbp_pkg::PER_W:0] trial;
  logic done_r;

  assign trial = {rem_r[ctbp_pkg::PER_W-1:0], num_r[ctbp_pkg::PROD_W-1]};

  always_comb begin
    num_nxt = {num_r[ctbp_pkg::PROD_W-2:0], 1'b0};
    if (trial >= {1'b0, per_r}) begin
      rem_nxt = trial - {1'b0, per_r};
      q_nxt = {q_r[ctbp_pkg::SIZE_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      q_nxt = {q_r[ctbp_pkg::SIZE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 2'd0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      ph_r <= 2'd1;
      per_r <= (period == '0) ? ctbp_pkg::PER_W'(1) : period;
      el_r <= elapsed;
      size_r <= size;
    end else if (ph_r == 2'd1) begin
      cap_r <= per_r * size_r;
      ph_r <= 2'd2;
    end else if (ph_r == 2'd2) begin
      // clamp so the quotient fits size bits
      num_r <= ({{(ctbp_pkg::TIME_W-ctbp_pkg::PROD_W){1'b0}}, cap_r} < el_r) ? cap_r
               : el_r[ctbp_pkg::PROD_W-1:0];
      rem_r <= '0;
      q_r <= '0;
      cnt_r <= CNT_W'(ctbp_pkg::PROD_W);
      ph_r <= 2'd3;
    end else if (ph_r == 2'd3) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) ph_r <= 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (ph_r == 2'd3) && (cnt_r == CNT_W'(1)) && !ctl.start;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* hdl/ctbp_checker.sv */
module ctbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_limited,
  input logic [1:0] out_outcome
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_outcome)) else $error("out held");
  a_lim_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_limited == out_outcome[1]) else $error("limited mismatch");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request overlap");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid) else $error("accept");

endmodule

bind client_token_bucket_policer ctbp_checker u_ctbp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_limited(out_limited),
  .out_outcome(out_outcome)
);
